FILE: rtl/core/tocu_pkg.sv
// ============================================================================
// tocu_pkg - shared types and constants for the timestamp order check
// Widths, limits and the per-record structs passed between the check
// and unwrap stages.
// ============================================================================
package tocu_pkg;

    // Board and time geometry
    localparam int NUM_BOARDS  = 16;
    localparam int BOARD_IN_W  = 4;
    localparam int BOARD_IDX_W = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
    localparam int TIME_BITS   = 30;
    localparam int WRAP_W      = 32;
    localparam int CORR_W      = 62;
    localparam int TALLY_W     = 16;

    localparam logic [TALLY_W-1:0]   TALLY_MAX      = '1;
    localparam logic [WRAP_W-1:0]    WRAP_MAX       = '1;
    localparam logic [TIME_BITS-1:0] MAX_DIFF_RESET = TIME_BITS'(10000000);

    // One input word as held in the input register
    typedef struct packed {
        logic [BOARD_IN_W-1:0] board_index;
        logic [TIME_BITS-1:0]  timestamp;
        logic                  is_reference;
        logic                  is_overflow;
        logic                  last_of_batch;
    } rec_t;

    // Step control from the order check to the unwrap stage
    typedef struct packed {
        logic advance;
        logic accept;
    } step_t;

    // Fold a raw board number onto the implemented boards
    function automatic logic [BOARD_IDX_W-1:0] board_slot(input logic [BOARD_IN_W-1:0] idx);
        logic [BOARD_IDX_W-1:0] slot;
        slot = '0;
        for (int k = 0; k < (1 << BOARD_IN_W); k++) begin
            if (idx == BOARD_IN_W'(k)) begin
                slot = BOARD_IDX_W'(k % NUM_BOARDS);
            end
        end
        return slot;
    endfunction

endpackage

FILE: rtl/core/tocu_check.sv
// ============================================================================
// tocu_check - batch order check and drop tally
// Decides whether the held word is kept and tracks the per-batch state:
// previous kept time, reference flag, drop mode and saturating drop count.
// ============================================================================
module tocu_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tocu_pkg::rec_t                 rec,
    input  logic                           advance,
    input  logic [tocu_pkg::TIME_BITS-1:0] step_limit,
    output tocu_pkg::step_t                step,
    output logic [tocu_pkg::TALLY_W-1:0]   dropped_count
);

    logic [tocu_pkg::TIME_BITS-1:0] prev_time_reg, prev_time_next;
    logic                           prev_ref_reg, prev_ref_next;
    logic                           dropping_reg, dropping_next;
    logic                           batch_start_reg, batch_start_next;
    logic [tocu_pkg::TALLY_W-1:0]   tally_reg, tally_next;

    logic                           accept;
    logic [tocu_pkg::TIME_BITS-1:0] step_size;
    logic [tocu_pkg::TALLY_W-1:0]   tally_base;
    logic [tocu_pkg::TALLY_W-1:0]   tally_new;

    // Decide keep or drop for the held word
    always_comb begin
        step_size = rec.timestamp - prev_time_reg;
        if (batch_start_reg) begin
            accept = 1'b1;
        end else if (dropping_reg) begin
            accept = 1'b0;
        end else if (rec.timestamp <= prev_time_reg) begin
            accept = prev_ref_reg | rec.is_overflow;
        end else begin
            accept = (step_size <= step_limit);
        end
    end

    // Count drops, saturating; a new batch starts from zero
    always_comb begin
        tally_base = batch_start_reg ? '0 : tally_reg;
        if (!accept && (tally_base != tocu_pkg::TALLY_MAX)) begin
            tally_new = tally_base + 1'b1;
        end else begin
            tally_new = tally_base;
        end
    end

    // Next batch state; batch end reopens the batch
    always_comb begin
        prev_time_next   = accept ? rec.timestamp : prev_time_reg;
        prev_ref_next    = accept ? rec.is_reference : prev_ref_reg;
        if (rec.last_of_batch) begin
            batch_start_next = 1'b1;
            dropping_next    = 1'b0;
            tally_next       = '0;
        end else begin
            batch_start_next = 1'b0;
            dropping_next    = (dropping_reg & ~batch_start_reg) | ~accept;
            tally_next       = tally_new;
        end
    end

    // Advance batch state with each word taken into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg   <= '0;
            prev_ref_reg    <= 1'b0;
            dropping_reg    <= 1'b0;
            batch_start_reg <= 1'b1;
            tally_reg       <= '0;
        end else if (advance) begin
            prev_time_reg   <= prev_time_next;
            prev_ref_reg    <= prev_ref_next;
            dropping_reg    <= dropping_next;
            batch_start_reg <= batch_start_next;
            tally_reg       <= tally_next;
        end
    end

    assign step.advance  = advance;
    assign step.accept   = accept;
    assign dropped_count = rec.last_of_batch ? tally_new : '0;

endmodule

FILE: rtl/core/tocu_unwrap.sv
// ============================================================================
// tocu_unwrap - per-board wraparound unwrapping
// Holds each board's wrap count and last kept time, raises the count on a
// falling overflow word and forms the corrected time of kept words.
// ============================================================================
module tocu_unwrap (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tocu_pkg::rec_t              rec,
    input  tocu_pkg::step_t             step,
    output logic [tocu_pkg::CORR_W-1:0] corr_time
);

    logic [tocu_pkg::WRAP_W-1:0]    wrap_reg [tocu_pkg::NUM_BOARDS];
    logic [tocu_pkg::TIME_BITS-1:0] last_reg [tocu_pkg::NUM_BOARDS];
    logic [tocu_pkg::WRAP_W-1:0]    wrap_next;
    logic [tocu_pkg::TIME_BITS-1:0] last_next;

    logic [tocu_pkg::BOARD_IDX_W-1:0] slot;
    logic [tocu_pkg::WRAP_W-1:0]      wrap_cur;
    logic [tocu_pkg::WRAP_W-1:0]      wrap_new;
    logic                             wrap_up;

    assign slot     = tocu_pkg::board_slot(rec.board_index);
    assign wrap_cur = wrap_reg[slot];

    // Raise the wrap count on a falling overflow word, saturating
    always_comb begin
        wrap_up = ~rec.is_reference & rec.is_overflow & (rec.timestamp < last_reg[slot]);
        if (wrap_up && (wrap_cur != tocu_pkg::WRAP_MAX)) begin
            wrap_new = wrap_cur + 1'b1;
        end else begin
            wrap_new = wrap_cur;
        end
    end

    // Stamp kept words; dropped words carry zero
    always_comb begin
        if (step.accept) begin
            corr_time = (tocu_pkg::CORR_W'(wrap_new) << tocu_pkg::TIME_BITS)
                      | tocu_pkg::CORR_W'(rec.timestamp);
        end else begin
            corr_time = '0;
        end
    end

    // A reference clears the board after stamping
    always_comb begin
        if (rec.is_reference) begin
            wrap_next = '0;
            last_next = '0;
        end else begin
            wrap_next = wrap_new;
            last_next = rec.timestamp;
        end
    end

    // Update only the addressed board, only for kept words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < tocu_pkg::NUM_BOARDS; b++) begin
                wrap_reg[b] <= '0;
                last_reg[b] <= '0;
            end
        end else if (step.advance && step.accept) begin
            wrap_reg[slot] <= wrap_next;
            last_reg[slot] <= last_next;
        end
    end

endmodule

FILE: rtl/core/timestamp_order_check_unwrap_core.sv
// ============================================================================
// timestamp_order_check_unwrap_core - board record order check and unwrap
// Top level: input register, check and unwrap logic, result register.
// ============================================================================
//
// Usage:
//   Input channel s_*: one board event record per word, batches closed by
//   s_last_of_batch. Result channel m_*: one result word per input word, in
//   order, with keep flag, corrected 62-bit time, reference flag, drop count
//   (on the batch's last word) and batch end flag.
//   cfg_wr_en/cfg_wr_data load the step limit register; write it only
//   while no words are in flight.
// Timing:
//   A taken word sits in the input register and moves on into the result
//   register when that is free or being taken, which raises m_valid.
//   Throughput, while results are taken, is one word per cycle, set by the
//   combinational check and per-board register update in between.
// Reset and stall:
//   Reset empties both registers, opens a new batch, clears every board's
//   wrap count and last time and loads the step limit with 10000000.
//   While m_ready is low the result holds; one more word may be taken into
//   the input register, then s_ready drops until the result is taken.
//
module timestamp_order_check_unwrap_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tocu_pkg::TIME_BITS-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tocu_pkg::BOARD_IN_W-1:0] s_board_index,
    input  logic [tocu_pkg::TIME_BITS-1:0]  s_timestamp,
    input  logic                            s_is_reference,
    input  logic                            s_is_overflow,
    input  logic                            s_last_of_batch,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accepted,
    output logic [tocu_pkg::CORR_W-1:0]     m_corrected_time,
    output logic                            m_reference_seen,
    output logic [tocu_pkg::TALLY_W-1:0]    m_dropped_count,
    output logic                            m_batch_end
);

    logic [tocu_pkg::TIME_BITS-1:0] max_diff_reg;
    logic                           in_valid_reg;
    tocu_pkg::rec_t                 in_rec_reg;
    logic                           out_valid_reg;
    logic                           out_accepted_reg;
    logic [tocu_pkg::CORR_W-1:0]    out_corr_reg;
    logic                           out_ref_reg;
    logic [tocu_pkg::TALLY_W-1:0]   out_drop_reg;
    logic                           out_end_reg;

    logic                           advance;
    tocu_pkg::step_t                step;
    logic [tocu_pkg::TALLY_W-1:0]   dropped_count;
    logic [tocu_pkg::CORR_W-1:0]    corr_time;

    // Move the held word on when the result register is free or being taken
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    // Hold the limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_diff_reg <= tocu_pkg::MAX_DIFF_RESET;
        end else if (cfg_wr_en) begin
            max_diff_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_rec_reg.board_index   <= s_board_index;
            in_rec_reg.timestamp     <= s_timestamp;
            in_rec_reg.is_reference  <= s_is_reference;
            in_rec_reg.is_overflow   <= s_is_overflow;
            in_rec_reg.last_of_batch <= s_last_of_batch;
        end
    end

    tocu_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rec           (in_rec_reg),
        .advance       (advance),
        .step_limit    (max_diff_reg),
        .step          (step),
        .dropped_count (dropped_count)
    );

    tocu_unwrap u_unwrap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec       (in_rec_reg),
        .step      (step),
        .corr_time (corr_time)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_accepted_reg <= step.accept;
            out_corr_reg     <= corr_time;
            out_ref_reg      <= step.accept & in_rec_reg.is_reference;
            out_drop_reg     <= dropped_count;
            out_end_reg      <= in_rec_reg.last_of_batch;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_accepted       = out_accepted_reg;
    assign m_corrected_time = out_corr_reg;
    assign m_reference_seen = out_ref_reg;
    assign m_dropped_count  = out_drop_reg;
    assign m_batch_end      = out_end_reg;

    // A dropped word carries no time and no reference flag
    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> (m_corrected_time == '0) && !m_reference_seen)
        else $error("dropped word carries time or reference flag");

    // The drop count shows only on the batch's last word
    a_count_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_batch_end |-> m_dropped_count == '0)
        else $error("drop count reported before batch end");

    // A stalled result stays in place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corrected_time)
            && $stable(m_accepted) && $stable(m_dropped_count))
        else $error("result changed while stalled");

    // A kept reference is never reported as a drop
    a_ref_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reference_seen |-> m_accepted)
        else $error("reference flag on a dropped word");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - timestamp order check and unwrap, self-checking bench
// Feeds board event records through the valid/ready input channel, predicts
// the keep flag, corrected time, reference flag, drop count and batch end of
// every word, and compares each result word in order against the oldest
// prediction. Runs a directed opening and random batches under several
// step limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam logic [tocu_pkg::TIME_BITS-1:0] TIME_TOP = '1;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_WORDS = 190;

    typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_t;

    typedef struct {
        tocu_pkg::rec_t rec;
        int             gap;
    } word_t;

    typedef struct packed {
        logic                           accepted;
        logic [tocu_pkg::CORR_W-1:0]    corr_time;
        logic                           reference_seen;
        logic [tocu_pkg::TALLY_W-1:0]   dropped_count;
        logic                           batch_end;
    } verdict_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [tocu_pkg::TIME_BITS-1:0]  cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [tocu_pkg::BOARD_IN_W-1:0] s_board_index = '0;
    logic [tocu_pkg::TIME_BITS-1:0]  s_timestamp = '0;
    logic                            s_is_reference = 1'b0;
    logic                            s_is_overflow = 1'b0;
    logic                            s_last_of_batch = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_accepted;
    logic [tocu_pkg::CORR_W-1:0]     m_corrected_time;
    logic                            m_reference_seen;
    logic [tocu_pkg::TALLY_W-1:0]    m_dropped_count;
    logic                            m_batch_end;

    // Words waiting to be sent and results waiting to arrive
    word_t    pending[$];
    verdict_t expected[$];

    // Predictor copy of the block's state and register
    logic [tocu_pkg::TIME_BITS-1:0] limit_shadow;
    logic [tocu_pkg::TIME_BITS-1:0] prev_kept_time;
    logic                           last_ref;
    logic                           batch_dropping;
    logic                           batch_open;
    logic [tocu_pkg::TALLY_W-1:0]   tally;
    logic [tocu_pkg::WRAP_W-1:0]    wraps[tocu_pkg::NUM_BOARDS];
    logic [tocu_pkg::TIME_BITS-1:0] board_last[tocu_pkg::NUM_BOARDS];

    pace_t    rx_pace = PACE_SPARSE;
    int       gap_cnt;
    int       stall_cnt;
    int       stall_next;
    int       in_count;
    int       hold_left;
    int       quiet_cycles;
    int       err_count = 0;
    word_t    offer;
    verdict_t due;

    timestamp_order_check_unwrap_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_board_index    (s_board_index),
        .s_timestamp      (s_timestamp),
        .s_is_reference   (s_is_reference),
        .s_is_overflow    (s_is_overflow),
        .s_last_of_batch  (s_last_of_batch),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_corrected_time (m_corrected_time),
        .m_reference_seen (m_reference_seen),
        .m_dropped_count  (m_dropped_count),
        .m_batch_end      (m_batch_end)
    );

    always #5 aclk = ~aclk;

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_NONE: return 0;
            PACE_FULL: return $urandom_range(0, 14);
            default:   return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    // Judge one record against the batch history and unwrap its time
    function automatic verdict_t judge_record(input tocu_pkg::rec_t r);
        int       slot;
        logic     keep;
        verdict_t v;
        slot = int'(r.board_index) % tocu_pkg::NUM_BOARDS;
        if (batch_open) begin
            keep = 1'b1;
            batch_dropping = 1'b0;
            tally = '0;
        end else if (batch_dropping) begin
            keep = 1'b0;
        end else if (r.timestamp <= prev_kept_time) begin
            keep = last_ref || r.is_overflow;
        end else begin
            keep = tocu_pkg::TIME_BITS'(r.timestamp - prev_kept_time) <= limit_shadow;
        end
        batch_open = 1'b0;
        v = '0;
        if (keep) begin
            prev_kept_time = r.timestamp;
            last_ref = r.is_reference;
            // time fell on an overflow word: count one more wrap
            if (!r.is_reference && r.is_overflow && r.timestamp < board_last[slot]) begin
                if (wraps[slot] != tocu_pkg::WRAP_MAX) begin
                    wraps[slot] = wraps[slot] + 1'b1;
                end
            end
            v.corr_time = tocu_pkg::CORR_W'({wraps[slot], r.timestamp});
            if (r.is_reference) begin
                wraps[slot] = '0;
                board_last[slot] = '0;
            end else begin
                board_last[slot] = r.timestamp;
            end
        end else begin
            batch_dropping = 1'b1;
            if (tally != tocu_pkg::TALLY_MAX) begin
                tally = tally + 1'b1;
            end
        end
        v.accepted = keep;
        v.reference_seen = keep && r.is_reference;
        v.dropped_count = r.last_of_batch ? tally : '0;
        v.batch_end = r.last_of_batch;
        if (r.last_of_batch) begin
            batch_open = 1'b1;
            batch_dropping = 1'b0;
            tally = '0;
        end
        return v;
    endfunction

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            err_count++;
        end
    endtask

    task automatic push_rec(input logic [tocu_pkg::BOARD_IN_W-1:0] b,
                            input logic [tocu_pkg::TIME_BITS-1:0] ts,
                            input logic r, input logic o, input logic l, input pace_t pace);
        word_t w;
        w.rec.board_index = b;
        w.rec.timestamp = ts;
        w.rec.is_reference = r;
        w.rec.is_overflow = o;
        w.rec.last_of_batch = l;
        w.gap = draw_wait(pace);
        pending.push_back(w);
    endtask

    // Wait until every word is sent and answered, then let the pipe settle
    task automatic settle_block();
        @(negedge aclk);
        while (pending.size() != 0 || s_valid || expected.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [tocu_pkg::TIME_BITS-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender: offer the next word once its gap has passed, hold until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else if (!s_valid || s_ready) begin
            if (pending.size() != 0 && gap_cnt >= pending[0].gap) begin
                offer = pending.pop_front();
                s_valid <= 1'b1;
                s_board_index <= offer.rec.board_index;
                s_timestamp <= offer.rec.timestamp;
                s_is_reference <= offer.rec.is_reference;
                s_is_overflow <= offer.rec.is_overflow;
                s_last_of_batch <= offer.rec.last_of_batch;
                gap_cnt <= 0;
            end else begin
                s_valid <= 1'b0;
                if (pending.size() != 0) begin
                    gap_cnt <= gap_cnt + 1;
                end
            end
        end
    end

    // Receiver: predict on every input word, check every result word
    always @(posedge aclk) begin
        if (!aresetn) begin
            limit_shadow = tocu_pkg::MAX_DIFF_RESET;
            prev_kept_time = '0;
            last_ref = 1'b0;
            batch_dropping = 1'b0;
            batch_open = 1'b1;
            tally = '0;
            for (int i = 0; i < tocu_pkg::NUM_BOARDS; i++) begin
                wraps[i] = '0;
                board_last[i] = '0;
            end
            m_ready <= 1'b0;
            stall_cnt <= 0;
            in_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                limit_shadow = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected.push_back(judge_record(tocu_pkg::rec_t'({s_board_index,
                    s_timestamp, s_is_reference, s_is_overflow, s_last_of_batch})));
                in_count <= in_count + 1;
            end
            stall_next = (stall_cnt != 0) ? stall_cnt - 1 : 0;
            if (m_valid && m_ready) begin
                if (expected.size() == 0) begin
                    $display("%0t: result word with nothing expected", $time);
                    err_count++;
                end else begin
                    due = expected.pop_front();
                    check_field("accepted", 64'(due.accepted), 64'(m_accepted));
                    check_field("corr_time", 64'(due.corr_time),
                                64'(m_corrected_time));
                    check_field("reference_seen", 64'(due.reference_seen),
                                64'(m_reference_seen));
                    check_field("dropped_count", 64'(due.dropped_count),
                                64'(m_dropped_count));
                    check_field("batch_end", 64'(due.batch_end), 64'(m_batch_end));
                end
                stall_next = draw_wait(rx_pace);
            end
            stall_cnt <= stall_next;
            m_ready <= (stall_next == 0) && (hold_left == 0);
        end
    end

    // Long receiver hold-off so the block fills and stalls its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (s_valid && s_ready && (in_count == 400 || in_count == 1100)) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [tocu_pkg::TIME_BITS-1:0]  limits[7];
        logic [tocu_pkg::TIME_BITS-1:0]  lim;
        logic [tocu_pkg::TIME_BITS-1:0]  t;
        logic [tocu_pkg::TIME_BITS-1:0]  ts;
        logic [tocu_pkg::BOARD_IN_W-1:0] brd;
        logic                            ref_f;
        logic                            ovf_f;
        pace_t                           tx_pace;
        int                              len;
        int                              kind;
        int                              n_left;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening under the reset limit of 10000000
        push_rec(4'd0, 30'd0, 1'b0, 1'b0, 1'b0, PACE_SPARSE);
        push_rec(4'd0, 30'd0, 1'b0, 1'b0, 1'b0, PACE_SPARSE);      // equal time: reject
        push_rec(4'd0, 30'd5, 1'b0, 1'b0, 1'b1, PACE_SPARSE);      // dropped, count 2
        push_rec(4'd15, TIME_TOP, 1'b0, 1'b0, 1'b1, PACE_SPARSE);  // one-word batch
        push_rec(4'd15, 30'd100, 1'b0, 1'b1, 1'b0, PACE_SPARSE);   // wrap on batch opener
        push_rec(4'd15, 30'd50, 1'b0, 1'b1, 1'b0, PACE_SPARSE);    // falls with overflow
        push_rec(4'd15, 30'd60, 1'b0, 1'b0, 1'b0, PACE_SPARSE);
        push_rec(4'd15, 30'd10000061, 1'b0, 1'b0, 1'b1, PACE_SPARSE); // step one too far
        push_rec(4'd3, 30'd1000, 1'b1, 1'b0, 1'b0, PACE_SPARSE);   // reference
        push_rec(4'd3, 30'd10, 1'b0, 1'b0, 1'b0, PACE_SPARSE);     // falls after reference
        push_rec(4'd3, 30'd10000010, 1'b0, 1'b0, 1'b0, PACE_SPARSE); // step at the limit
        push_rec(4'd3, 30'd20000010, 1'b1, 1'b1, 1'b0, PACE_SPARSE); // reference and overflow
        push_rec(4'd3, 30'd5, 1'b0, 1'b1, 1'b1, PACE_SPARSE);
        push_rec(4'd15, 30'd7, 1'b1, 1'b0, 1'b1, PACE_SPARSE);     // reference clears wraps
        push_rec(4'd15, 30'd3, 1'b0, 1'b1, 1'b1, PACE_SPARSE);
        push_rec(4'd8, 30'd200, 1'b0, 1'b0, 1'b0, PACE_SPARSE);
        push_rec(4'd8, 30'd300, 1'b0, 1'b1, 1'b0, PACE_SPARSE);    // overflow, time rising
        push_rec(4'd8, 30'd300, 1'b0, 1'b0, 1'b0, PACE_SPARSE);
        push_rec(4'd8, 30'd400, 1'b0, 1'b0, 1'b0, PACE_SPARSE);
        push_rec(4'd8, 30'd401, 1'b1, 1'b1, 1'b1, PACE_SPARSE);
        settle_block();

        // Random batches, one limit setting per phase
        limits = '{30'd0, 30'd1, 30'd1000, 30'd10000000, TIME_TOP, 30'd0, 30'd5000000};
        limits[5] = 30'($urandom());
        for (int phase = 0; phase < 7; phase++) begin
            lim = limits[phase];
            tx_pace = pace_t'(phase % 3);
            write_limit(lim);
            @(negedge aclk);
            rx_pace = pace_t'((phase + 1) % 3);
            n_left = PHASE_WORDS;
            while (n_left > 0) begin
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 14);
                brd = tocu_pkg::BOARD_IN_W'($urandom());
                // open some batches just below the top so the counter wraps
                t = ($urandom_range(0, 2) == 0) ?
                    tocu_pkg::TIME_BITS'(TIME_TOP - $urandom_range(0, 4000000)) :
                    tocu_pkg::TIME_BITS'($urandom());
                for (int k = 0; k < len; k++) begin
                    ref_f = ($urandom_range(0, 15) == 0);
                    ovf_f = ($urandom_range(0, 19) == 0);
                    kind = $urandom_range(0, 99);
                    if (k == 0) begin
                        ts = t;
                    end else if (kind < 70) begin
                        ts = tocu_pkg::TIME_BITS'(t + ((lim == 0) ? 1 :
                            $urandom_range(1, (lim > 3000000) ? 3000000 : lim)));
                        if (ts < t) begin
                            ovf_f = 1'b1;
                        end
                    end else if (kind < 76) begin
                        ts = t;
                    end else if (kind < 82) begin
                        ts = tocu_pkg::TIME_BITS'(t - $urandom_range(1, 1000));
                    end else if (kind < 88) begin
                        ts = tocu_pkg::TIME_BITS'($urandom_range(0, 1000));
                        ovf_f = 1'b1;
                    end else if (kind < 94) begin
                        ts = (lim == TIME_TOP) ? tocu_pkg::TIME_BITS'($urandom()) :
                            tocu_pkg::TIME_BITS'(t + lim + 1 + $urandom_range(0, 3));
                    end else begin
                        ts = tocu_pkg::TIME_BITS'(t + lim);
                    end
                    push_rec(($urandom_range(0, 31) == 0) ?
                             tocu_pkg::BOARD_IN_W'($urandom()) : brd,
                             ts, ref_f, ovf_f, k == len - 1, tx_pace);
                    t = ts;
                end
                n_left -= len;
            end
            settle_block();
        end

        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tocu_pkg.sv
rtl/core/tocu_check.sv
rtl/core/tocu_unwrap.sv
rtl/core/timestamp_order_check_unwrap_core.sv
tb/sv/tb_top.sv
